// File: hw/rtl/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared constants for the two-point similarity solver: default coordinate
// and fraction widths, and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package tpss_pkg;

  localparam int COORD_BITS_DEF = 16;  // signed pixel coordinate width
  localparam int FRAC_BITS_DEF  = 16;  // fraction bits of a, b, dx, dy

  localparam int COEF_W  = 40;         // scale_cos / scale_sin field width
  localparam int SHIFT_W = 56;         // shift_x / shift_y field width

endpackage

// File: hw/rtl/tpss_if.sv
// ----------------------------------------------------------------------------
// tpss channel interfaces
// Valid/ready channels for tie-point sets in and transforms out. A beat
// moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tpss_in_if #(
  parameter int COORD_BITS = tpss_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ref_x1;
  logic signed [COORD_BITS-1:0] ref_y1;
  logic signed [COORD_BITS-1:0] sec_x1;
  logic signed [COORD_BITS-1:0] sec_y1;
  logic signed [COORD_BITS-1:0] ref_x2;
  logic signed [COORD_BITS-1:0] ref_y2;
  logic signed [COORD_BITS-1:0] sec_x2;
  logic signed [COORD_BITS-1:0] sec_y2;

  modport source (
    output valid, ref_x1, ref_y1, sec_x1, sec_y1, ref_x2, ref_y2, sec_x2, sec_y2,
    input  ready
  );
  modport sink (
    input  valid, ref_x1, ref_y1, sec_x1, sec_y1, ref_x2, ref_y2, sec_x2, sec_y2,
    output ready
  );
endinterface

interface tpss_out_if;
  import tpss_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COEF_W-1:0]  scale_cos;
  logic signed [COEF_W-1:0]  scale_sin;
  logic signed [SHIFT_W-1:0] shift_x;
  logic signed [SHIFT_W-1:0] shift_y;
  logic                      singular;

  modport source (
    output valid, scale_cos, scale_sin, shift_x, shift_y, singular,
    input  ready
  );
  modport sink (
    input  valid, scale_cos, scale_sin, shift_x, shift_y, singular,
    output ready
  );
endinterface

// File: hw/rtl/two_point_similarity_solver.sv
// ----------------------------------------------------------------------------
// two_point_similarity_solver
// The divider is restoring, with one quotient bit per stage.
// Throughput: one tie-point set per cycle; a stalled output freezes the whole
//   pipeline in place.
// Reset: synchronous, active low, clears only the stage valid bits.
// ----------------------------------------------------------------------------
module two_point_similarity_solver #(
  parameter int COORD_BITS = tpss_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tpss_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tpss_in_if.sink      in_ch,
  tpss_out_if.source   out_ch
);
  import tpss_pkg::*;

  // Widths
  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;               // coordinate delta
  localparam int SQW = 2 * C + 2;           // delta product
  localparam int NSW = 2 * C + 3;           // signed numerator
  localparam int NW  = 2 * C + 2;           // numerator magnitude
  localparam int RW  = 2 * C + 2;           // denominator / remainder
  // |a|,|b| <= |dr|/|ds| < 2^(C+2), so the quotient has C+2 integer bits
  localparam int IB  = C + 2;
  localparam int QW  = IB + FRAC_BITS;      // quotient bits = divider stages
  localparam int AW  = QW + 1;              // signed coefficient
  localparam int PW  = AW + C;              // coefficient * coordinate
  localparam int XW  = PW + 2;              // displacement sum

  // Whole pipeline advances together; a bubble at the output never stalls.
  logic adv;
  logic vout_r;

  assign adv         = !vout_r || out_ch.ready;
  assign in_ch.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: deltas of the two pairs, first pair kept for the offsets
  // --------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [DW-1:0] dsx_r, dsy_r, drx_r, dry_r;
  logic signed [C-1:0]  xr1_r, yr1_r, xs1_r, ys1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dsx_r <= DW'(in_ch.sec_x2) - DW'(in_ch.sec_x1);
      dsy_r <= DW'(in_ch.sec_y2) - DW'(in_ch.sec_y1);
      drx_r <= DW'(in_ch.ref_x2) - DW'(in_ch.ref_x1);
      dry_r <= DW'(in_ch.ref_y2) - DW'(in_ch.ref_y1);
      xr1_r <= in_ch.ref_x1;
      yr1_r <= in_ch.ref_y1;
      xs1_r <= in_ch.sec_x1;
      ys1_r <= in_ch.sec_y1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the six delta products
  // --------------------------------------------------------------------------
  logic                  v2_r;
  logic signed [SQW-1:0] sqx_r, sqy_r, pxx_r, pyy_r, pyx_r, pxy_r;
  logic signed [C-1:0]   xr2_r, yr2_r, xs2_r, ys2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= SQW'(dsx_r) * SQW'(dsx_r);
      sqy_r <= SQW'(dsy_r) * SQW'(dsy_r);
      pxx_r <= SQW'(drx_r) * SQW'(dsx_r);
      pyy_r <= SQW'(dry_r) * SQW'(dsy_r);
      pyx_r <= SQW'(dry_r) * SQW'(dsx_r);
      pxy_r <= SQW'(drx_r) * SQW'(dsy_r);
      xr2_r <= xr1_r;
      yr2_r <= yr1_r;
      xs2_r <= xs1_r;
      ys2_r <= ys1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: d = |ds|^2 and the two numerators
  // --------------------------------------------------------------------------
  logic                  v3_r;
  logic [RW-1:0]         den3_r;
  logic signed [NSW-1:0] na_r, nb_r;
  logic signed [C-1:0]   xr3_r, yr3_r, xs3_r, ys3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // squares are non-negative and below 2^(2C), sum fits RW unsigned
      den3_r <= $unsigned(sqx_r) + $unsigned(sqy_r);
      na_r   <= NSW'(pxx_r) + NSW'(pyy_r);
      nb_r   <= NSW'(pyx_r) - NSW'(pxy_r);
      xr3_r  <= xr2_r;
      yr3_r  <= yr2_r;
      xs3_r  <= xs2_r;
      ys3_r  <= ys2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4 and divider: sign/magnitude split, then one restoring step per
  // stage. Index 0 of each array is the divider entry.
  // --------------------------------------------------------------------------
  logic [NW-1:0] maga_nxt, magb_nxt;

  assign maga_nxt = na_r[NSW-1] ? NW'(-na_r) : NW'(na_r);
  assign magb_nxt = nb_r[NSW-1] ? NW'(-nb_r) : NW'(nb_r);

  logic                dv_v_r   [0:QW];
  logic [RW-1:0]       den_r    [0:QW];
  logic [RW-1:0]       rema_r   [0:QW];
  logic [RW-1:0]       remb_r   [0:QW];
  logic [QW-1:0]       resta_r  [0:QW];   // dividend bits out, quotient bits in
  logic [QW-1:0]       restb_r  [0:QW];
  logic                nega_r   [0:QW];
  logic                negb_r   [0:QW];
  logic                sing_r   [0:QW];
  logic signed [C-1:0] xr_r     [0:QW];
  logic signed [C-1:0] yr_r     [0:QW];
  logic signed [C-1:0] xs_r     [0:QW];
  logic signed [C-1:0] ys_r     [0:QW];

  // One quotient bit: returns {remainder, shifted dividend/quotient}
  function automatic logic [RW+QW-1:0] div_step(
    input logic [RW-1:0] rem,
    input logic [QW-1:0] rest,
    input logic [RW-1:0] den
  );
    logic [RW:0] t;
    logic [RW:0] diff;
    t    = {rem, rest[QW-1]};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {diff[RW-1:0], rest[QW-2:0], 1'b1};
    end else begin
      return {t[RW-1:0], rest[QW-2:0], 1'b0};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      // the integer quotient is below 2^IB, so the top bits of the
      // magnitude are already a valid partial remainder (less than d)
      den_r[0]   <= den3_r;
      rema_r[0]  <= {{IB{1'b0}}, maga_nxt[NW-1:IB]};
      remb_r[0]  <= {{IB{1'b0}}, magb_nxt[NW-1:IB]};
      resta_r[0] <= {maga_nxt[IB-1:0], {FRAC_BITS{1'b0}}};
      restb_r[0] <= {magb_nxt[IB-1:0], {FRAC_BITS{1'b0}}};
      nega_r[0]  <= na_r[NSW-1];
      negb_r[0]  <= nb_r[NSW-1];
      sing_r[0]  <= (den3_r == '0);
      xr_r[0]    <= xr3_r;
      yr_r[0]    <= yr3_r;
      xs_r[0]    <= xs3_r;
      ys_r[0]    <= ys3_r;
      for (int k = 0; k < QW; k++) begin
        {rema_r[k+1], resta_r[k+1]} <= div_step(rema_r[k], resta_r[k], den_r[k]);
        {remb_r[k+1], restb_r[k+1]} <= div_step(remb_r[k], restb_r[k], den_r[k]);
        den_r[k+1]  <= den_r[k];
        nega_r[k+1] <= nega_r[k];
        negb_r[k+1] <= negb_r[k];
        sing_r[k+1] <= sing_r[k];
        xr_r[k+1]   <= xr_r[k];
        yr_r[k+1]   <= yr_r[k];
        xs_r[k+1]   <= xs_r[k];
        ys_r[k+1]   <= ys_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: signed coefficients (truncation toward zero)
  // --------------------------------------------------------------------------
  logic                 va_r;
  logic signed [AW-1:0] coa_r, cob_r;
  logic                 singa_r;
  logic signed [C-1:0]  xra_r, yra_r, xsa_r, ysa_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      coa_r   <= nega_r[QW] ? -$signed({1'b0, resta_r[QW]}) : $signed({1'b0, resta_r[QW]});
      cob_r   <= negb_r[QW] ? -$signed({1'b0, restb_r[QW]}) : $signed({1'b0, restb_r[QW]});
      singa_r <= sing_r[QW];
      xra_r   <= xr_r[QW];
      yra_r   <= yr_r[QW];
      xsa_r   <= xs_r[QW];
      ysa_r   <= ys_r[QW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: coefficient times first secondary point
  // --------------------------------------------------------------------------
  logic                 vb_r;
  logic signed [PW-1:0] pax_r, pby_r, pbx_r, pay_r;
  logic signed [AW-1:0] cob_b_r, coa_b_r;
  logic                 singb_r;
  logic signed [C-1:0]  xrb_r, yrb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pax_r   <= PW'(coa_r) * PW'(xsa_r);
      pby_r   <= PW'(cob_r) * PW'(ysa_r);
      pbx_r   <= PW'(cob_r) * PW'(xsa_r);
      pay_r   <= PW'(coa_r) * PW'(ysa_r);
      coa_b_r <= coa_r;
      cob_b_r <= cob_r;
      singb_r <= singa_r;
      xrb_r   <= xra_r;
      yrb_r   <= yra_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: offsets, zeroing of coincident secondary points
  // --------------------------------------------------------------------------
  logic signed [XW-1:0]      dx_nxt, dy_nxt;
  logic signed [COEF_W-1:0]  scale_cos_r, scale_sin_r;
  logic signed [SHIFT_W-1:0] shift_x_r, shift_y_r;
  logic                      singular_r;

  assign dx_nxt = (XW'(xrb_r) <<< FRAC_BITS) - XW'(pax_r) + XW'(pby_r);
  assign dy_nxt = (XW'(yrb_r) <<< FRAC_BITS) - XW'(pbx_r) - XW'(pay_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      singular_r <= singb_r;
      if (singb_r) begin
        scale_cos_r <= '0;
        scale_sin_r <= '0;
        shift_x_r   <= '0;
        shift_y_r   <= '0;
      end else begin
        scale_cos_r <= COEF_W'(coa_b_r);
        scale_sin_r <= COEF_W'(cob_b_r);
        shift_x_r   <= SHIFT_W'(dx_nxt);
        shift_y_r   <= SHIFT_W'(dy_nxt);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits ride along with the data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vout_r <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r      <= in_ch.valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      dv_v_r[0] <= v3_r;
      for (int k = 0; k < QW; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      va_r   <= dv_v_r[QW];
      vb_r   <= va_r;
      vout_r <= vb_r;
    end
  end

  assign out_ch.valid     = vout_r;
  assign out_ch.scale_cos = scale_cos_r;
  assign out_ch.scale_sin = scale_sin_r;
  assign out_ch.shift_x   = shift_x_r;
  assign out_ch.shift_y   = shift_y_r;
  assign out_ch.singular  = singular_r;

endmodule
